@@ rtl/assert_macros.svh @@
// Assertion macros used by the decompressor copy engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Assert that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`endif

@@ rtl/lzf_pkg.sv @@
// Shared types and constants for the LZF stream decompressor
package lzf_pkg;
  localparam int unsigned HistDepth = 8192;
  localparam int unsigned HistAw = 13;
  localparam int unsigned LaneBytes = 8;

  // Command kinds passed from the parser to the copy engine
  localparam logic [1:0] CMD_LIT  = 2'd0;
  localparam logic [1:0] CMD_COPY = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;      // literal byte
    logic [12:0] back_ofs; // copy distance minus one
    logic [8:0]  len;      // copy length
    logic        fin;      // last command of the stream, carries status and total
    logic [1:0]  status;   // end status
    logic [31:0] total;    // end total
  } cmd_t;
endpackage

@@ rtl/lzf_parser.sv @@
// Front end: parses compressed bytes into literal, copy and end commands
module lzf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       cap_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output lzf_pkg::cmd_t     cmd_o
);
  import lzf_pkg::*;

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_LIT = 2'd1;
  localparam logic [1:0] PH_EXTRA = 2'd2;
  localparam logic [1:0] PH_OFS = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [5:0]  lit_q, lit_d;
  logic [8:0]  mlen_q, mlen_d;
  logic [4:0]  ofsh_q, ofsh_d;
  logic        cnt_q, cnt_d, bad_q, bad_d;
  logic [31:0] bytes_q, bytes_d;
  logic        acc;
  logic [8:0]  klen;
  logic        known;
  logic [32:0] sum;
  logic        cnt_n;
  logic [12:0] back_ofs;
  logic        lit_emit, copy_emit;
  logic [1:0]  ph_n;
  logic        bad_n;
  logic [31:0] bytes_n;

  function automatic logic [31:0] sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign in_ready_o = cmd_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign back_ofs = {ofsh_q, in_byte_i};

  // Decode one byte
  always_comb begin
    ph_n = phase_q; lit_d = lit_q; mlen_d = mlen_q; ofsh_d = ofsh_q;
    cnt_n = cnt_q; bad_n = bad_q; bytes_n = bytes_q;
    known = 1'b0; klen = '0;
    lit_emit = 1'b0; copy_emit = 1'b0;
    if (!bad_q) begin
      case (phase_q)
        PH_CTRL: begin
          if (in_byte_i < 8'h20) begin
            lit_d = {1'b0, in_byte_i[4:0]} + 6'd1;
            known = 1'b1; klen = {3'd0, lit_d};
            ph_n = PH_LIT;
          end else begin
            ofsh_d = in_byte_i[4:0];
            if (in_byte_i[7:5] == 3'd7) ph_n = PH_EXTRA;
            else begin
              mlen_d = {6'd0, in_byte_i[7:5]} + 9'd2;
              known = 1'b1; klen = mlen_d;
              ph_n = PH_OFS;
            end
          end
        end
        PH_LIT: begin
          lit_emit = !cnt_q;
          if (!cnt_q) bytes_n = sat(bytes_q, 32'd1);
          lit_d = lit_q - 6'd1;
          if (lit_q == 6'd1) ph_n = PH_CTRL;
        end
        PH_EXTRA: begin
          mlen_d = {1'b0, in_byte_i} + 9'd9;
          known = 1'b1; klen = mlen_d;
          ph_n = PH_OFS;
        end
        default: begin
          if (!cnt_q) begin
            if ({19'd0, back_ofs} >= bytes_q) bad_n = 1'b1;
            else begin
              copy_emit = 1'b1;
              bytes_n = sat(bytes_q, {23'd0, mlen_q});
            end
          end
          ph_n = PH_CTRL;
        end
      endcase
    end
    sum = {1'b0, bytes_q} + {24'd0, klen};
    if (known) begin
      if (!cnt_q && sum > {1'b0, cap_i}) cnt_n = 1'b1;
      if (cnt_n) bytes_n = sat(bytes_q, {23'd0, klen});
    end
  end

  // Form the command; the end of the stream rides on it
  always_comb begin
    cmd_o = '0;
    cmd_valid_o = 1'b0;
    if (in_valid_i) begin
      if (lit_emit) begin
        cmd_o.kind = CMD_LIT; cmd_o.lit = in_byte_i;
      end else if (copy_emit) begin
        cmd_o.kind = CMD_COPY; cmd_o.back_ofs = back_ofs; cmd_o.len = mlen_q;
      end else begin
        cmd_o.kind = CMD_END;
      end
      cmd_valid_o = lit_emit || copy_emit || in_last_i;
      if (in_last_i) begin
        cmd_o.fin = 1'b1;
        cmd_o.status = (bad_n || ph_n != PH_CTRL) ? ST_CORRUPT : (cnt_n ? ST_OVER : ST_OK);
        cmd_o.total = bytes_n;
      end
    end
  end

  // Advance the stream state; the last byte returns it to its reset values
  always_comb begin
    phase_d = ph_n; cnt_d = cnt_n; bad_d = bad_n; bytes_d = bytes_n;
    if (in_last_i) begin
      phase_d = PH_CTRL; cnt_d = 1'b0; bad_d = 1'b0; bytes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL; lit_q <= '0; mlen_q <= '0; ofsh_q <= '0;
      cnt_q <= 1'b0; bad_q <= 1'b0; bytes_q <= '0;
    end else begin
      if (acc) begin
        phase_q <= phase_d; cnt_q <= cnt_d; bad_q <= bad_d; bytes_q <= bytes_d;
        lit_q <= in_last_i ? 6'd0 : lit_d;
        mlen_q <= in_last_i ? 9'd0 : mlen_d;
        ofsh_q <= in_last_i ? 5'd0 : ofsh_d;
      end
    end
  end
endmodule

@@ rtl/lzf_copy_engine.sv @@
// Back end: writes history, runs copies and packs bytes into results of up to 8 bytes
module lzf_copy_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  lzf_pkg::cmd_t     cmd_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [103:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  import lzf_pkg::*;
  `include "assert_macros.svh"

  logic [7:0]  hist [HistDepth];
  logic [12:0] widx_q;
  logic        busy_q;              // copy in progress
  logic [8:0]  left_q;
  logic [12:0] ridx_q;
  logic        rd_q;                // read data valid this cycle
  logic [7:0]  rdata_q;
  logic [63:0] pack_q;
  logic [3:0]  cnt_q;
  logic        ov_q;
  logic        fin_q;               // running copy closes the stream
  logic [1:0]  st_q;
  logic [31:0] tot_q;
  logic [103:0] out_q;
  logic        last_q;
  logic        room;                // result register free or freeing
  logic        take;
  logic        wr;
  logic [7:0]  wbyte;
  logic        flush, endf, done;
  logic [1:0]  est;
  logic [31:0] etot;
  logic [63:0] pk;
  logic [3:0]  ck;

  assign room = !ov_q || m_axis_tready;
  assign cmd_ready_o = !busy_q && !rd_q && room;
  assign take = cmd_valid_i && cmd_ready_o;

  // Choose the byte entering the packer and close the result when full or at command end
  always_comb begin
    wr = 1'b0; wbyte = rdata_q; done = 1'b0; endf = 1'b0;
    est = '0; etot = '0;
    if (rd_q) begin
      wr = 1'b1;
      if (left_q == 9'd1) begin
        done = 1'b1;
        if (fin_q) begin
          endf = 1'b1; est = st_q; etot = tot_q;
        end
      end
    end else if (take) begin
      if (cmd_i.kind == CMD_LIT) begin
        wr = 1'b1; wbyte = cmd_i.lit; done = 1'b1;
      end else if (cmd_i.kind == CMD_END) begin
        done = 1'b1;
      end
      if (cmd_i.kind != CMD_COPY && cmd_i.fin) begin
        endf = 1'b1; est = cmd_i.status; etot = cmd_i.total;
      end
    end
    pk = pack_q; ck = cnt_q;
    if (wr) begin
      pk[cnt_q[2:0]*8 +: 8] = wbyte;
      ck = cnt_q + 4'd1;
    end
    flush = (ck == 4'd8) || done;
  end

  // Step the copy and the packer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0; busy_q <= 1'b0; rd_q <= 1'b0; left_q <= '0; ridx_q <= '0;
      pack_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      fin_q <= 1'b0; st_q <= '0; tot_q <= '0;
    end else if (room) begin
      rd_q <= busy_q && !rd_q;
      if (take && cmd_i.kind == CMD_COPY) begin
        busy_q <= 1'b1; left_q <= cmd_i.len; ridx_q <= widx_q - cmd_i.back_ofs - 13'd1;
        fin_q <= cmd_i.fin; st_q <= cmd_i.status; tot_q <= cmd_i.total;
      end
      if (rd_q) begin
        ridx_q <= ridx_q + 13'd1;
        left_q <= left_q - 9'd1;
        if (left_q == 9'd1) busy_q <= 1'b0;
      end
      if (wr) widx_q <= widx_q + 13'd1;
      if (endf) widx_q <= '0;
      pack_q <= flush ? 64'd0 : pk;
      cnt_q <= flush ? 4'd0 : ck;
      ov_q <= flush;
    end
  end

  // History store and result register
  always_ff @(posedge clk_i) begin
    if (room && wr) hist[widx_q] <= wbyte;
    if (room && busy_q && !rd_q) rdata_q <= hist[ridx_q];
    if (room && flush) begin
      out_q <= {2'd0, etot, est, ck, pk};
      last_q <= endf;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;
  assign m_axis_tlast = last_q;

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q < 4'd8)
  `ASSERT_NEVER(a_no_take_busy, clk_i, rst_ni, busy_q && cmd_ready_o)
  `ASSERT_CLK(a_rd_in_copy, clk_i, rst_ni, !rd_q || busy_q)
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, ov_q && !m_axis_tready |=> ov_q && $stable(out_q))
endmodule

@@ rtl/lzf_stream_decompressor_unit.sv @@
// Top level of the LZF stream decompressor
// Path: a literal's result passes the command queue, then the result register;
// each literal byte is a result of its own.
// Throughput: one literal byte per cycle while the output is not stalled; a copy keeps the back
// end busy, each byte read from history, then written; input stalls on a full, untaken queue.
// Reset: asynchronous, clears parser, packer and capacity (all ones); history is
// not cleared and holds undefined data until written.
module lzf_stream_decompressor_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // in_byte
  input  logic         s_axis_tlast,   // in_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // out_data, out_count, out_status, out_total
  output logic         m_axis_tlast    // out_end
);
  import lzf_pkg::*;

  logic [31:0] cap_q;
  logic        cv;
  logic        cr;
  cmd_t        cmd;
  logic        qv_q;
  cmd_t        q_q;
  logic        qr;

  assign cfg_ready_o = 1'b1;

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 32'hFFFF_FFFF;
    else if (cfg_valid_i) cap_q <= cfg_data_i;
  end

  lzf_parser u_parse (
    .clk_i, .rst_ni, .cap_i(cap_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_last_i(s_axis_tlast),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(cmd)
  );

  // One-entry queue between front and back
  assign cr = !qv_q || qr;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qv_q <= 1'b0;
    else if (cr) qv_q <= cv;
  end
  always_ff @(posedge clk_i) begin
    if (cr) q_q <= cmd;
  end

  lzf_copy_engine u_copy (
    .clk_i, .rst_ni,
    .cmd_valid_i(qv_q), .cmd_ready_o(qr), .cmd_i(q_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );
endmodule
